// ===== hw/rtl/mmc_pkg.sv =====
// Shared types and constants for the magnetometer min/max calibration block.
// Used by mmc_div, mmc_lane and mag_minmax_hard_soft_iron_cal_top.
package mmc_pkg;

	localparam int AXES   = 3;
	localparam int SMP_W  = 24;
	localparam int SCL_W  = 16;
	localparam int CNT_W  = 16;
	localparam int D_W    = 24;
	localparam int SUM_W  = D_W + $clog2(AXES + 1);
	localparam int DEN_W  = D_W + $clog2(2 * AXES + 1);
	localparam int NUM_W  = SUM_W + 16;
	localparam int Q_W    = SCL_W + 1;
	localparam int QCNT_W = $clog2(Q_W);
	localparam int MUL1_W = SMP_W + 1 + SCL_W + 1;
	localparam int MUL2_W = MUL1_W + 17;
	localparam int RND_SH = 26;
	localparam int ADDR_W = 5;
	localparam int IDX_W  = 3;

	localparam logic [SCL_W-1:0] SCALE_SAT = '1;
	localparam logic signed [SMP_W-1:0] SMP_MAX = {1'b0, {(SMP_W-1){1'b1}}};
	localparam logic signed [SMP_W-1:0] SMP_MIN = {1'b1, {(SMP_W-1){1'b0}}};

	typedef enum logic [1:0] {
		MODE_IDLE    = 2'd0,
		MODE_COLLECT = 2'd1,
		MODE_COMPUTE = 2'd2,
		MODE_DONE    = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_CLEAR,
		OP_TRACK,
		OP_PRESET,
		OP_OFFS,
		OP_DIV
	} lane_op_t;

	typedef enum logic [IDX_W-1:0] {
		REG_TARGET = 3'd0,
		REG_INV    = 3'd1,
		REG_OFF_X  = 3'd2,
		REG_OFF_Y  = 3'd3,
		REG_OFF_Z  = 3'd4,
		REG_SCL_X  = 3'd5,
		REG_SCL_Y  = 3'd6,
		REG_SCL_Z  = 3'd7
	} reg_idx_t;

	typedef struct packed {
		lane_op_t         op;
		logic [SUM_W-1:0] sum;
	} lane_ctl_t;

	typedef struct packed {
		logic           busy;
		logic [D_W-1:0] d;
	} lane_sts_t;

endpackage

// ===== hw/rtl/mmc_div.sv =====
// Restoring divider, one quotient bit per cycle, saturating to 16 bits.
// Depends on mmc_pkg.
module mmc_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [mmc_pkg::NUM_W-1:0]   num,
	input  logic [mmc_pkg::DEN_W-1:0]   den,
	output logic                        busy,
	output logic                        done,
	output logic [mmc_pkg::SCL_W-1:0]   quo
);

	localparam int DSH_W = mmc_pkg::DEN_W + mmc_pkg::Q_W - 1;

	logic [mmc_pkg::NUM_W-1:0]  rem_q;
	logic [DSH_W-1:0]           dsh_q;
	logic [mmc_pkg::Q_W-1:0]    quo_q;
	logic [mmc_pkg::QCNT_W-1:0] cnt_q;
	logic                       busy_q;
	logic                       done_q;
	logic [mmc_pkg::SCL_W-1:0]  res_q;

	logic                       ovf;
	logic                       ge;
	logic [DSH_W-1:0]           rem_ext;
	logic [DSH_W-1:0]           diff;
	logic [mmc_pkg::Q_W-1:0]    quo_n;

	assign ovf = {{(DSH_W + 1 - mmc_pkg::NUM_W){1'b0}}, num} >= {den, {mmc_pkg::Q_W{1'b0}}};
	assign rem_ext = {{(DSH_W - mmc_pkg::NUM_W){1'b0}}, rem_q};
	assign ge = rem_ext >= dsh_q;
	assign diff = rem_ext - dsh_q;
	assign quo_n = {quo_q[mmc_pkg::Q_W-2:0], ge};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				if (ovf) begin
					res_q  <= mmc_pkg::SCALE_SAT;
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
				end
				rem_q <= num;
				dsh_q <= {den, {(mmc_pkg::Q_W-1){1'b0}}};
				quo_q <= '0;
				cnt_q <= mmc_pkg::QCNT_W'(mmc_pkg::Q_W - 1);
			end else if (busy_q) begin
				if (ge) begin
					rem_q <= diff[mmc_pkg::NUM_W-1:0];
				end
				quo_q <= quo_n;
				dsh_q <= dsh_q >> 1;
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
					res_q  <= quo_n[mmc_pkg::Q_W-1] ? mmc_pkg::SCALE_SAT
					                                 : quo_n[mmc_pkg::SCL_W-1:0];
				end
			end
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quo  = res_q;

endmodule

// ===== hw/rtl/mmc_lane.sv =====
// One axis lane: min/max tracking, offset and scale computation, correction pipeline.
// Depends on mmc_pkg and mmc_div.
module mmc_lane (
	input  logic                              clk,
	input  logic                              arst_n,
	input  mmc_pkg::lane_ctl_t                ctl,
	input  logic signed [mmc_pkg::SMP_W-1:0]  smp,
	input  logic signed [mmc_pkg::SMP_W-1:0]  preset_off,
	input  logic [mmc_pkg::SCL_W-1:0]         preset_scl,
	input  logic [15:0]                       inv,
	output mmc_pkg::lane_sts_t                sts,
	output logic signed [mmc_pkg::SMP_W-1:0]  res
);

	logic signed [mmc_pkg::SMP_W-1:0]  min_q;
	logic signed [mmc_pkg::SMP_W-1:0]  max_q;
	logic signed [mmc_pkg::SMP_W-1:0]  off_q;
	logic [mmc_pkg::SCL_W-1:0]         scale_q;
	logic [mmc_pkg::D_W-1:0]           d_q;
	logic signed [mmc_pkg::MUL1_W-1:0] mul1_s1;
	logic signed [mmc_pkg::MUL2_W-1:0] mul2_s2;
	logic signed [mmc_pkg::SMP_W-1:0]  res_q;

	logic signed [mmc_pkg::SMP_W:0]    pair_sum;
	logic signed [mmc_pkg::SMP_W:0]    span;
	logic signed [mmc_pkg::SMP_W:0]    diff;
	logic signed [mmc_pkg::MUL2_W-1:0] rnd;
	logic signed [mmc_pkg::MUL2_W-mmc_pkg::RND_SH-1:0] shifted;
	logic                              div_start;
	logic                              div_busy;
	logic                              div_done;
	logic [mmc_pkg::SCL_W-1:0]         div_quo;
	logic [mmc_pkg::NUM_W-1:0]         num;
	logic [mmc_pkg::DEN_W-1:0]         den;

	assign pair_sum = {max_q[mmc_pkg::SMP_W-1], max_q} + {min_q[mmc_pkg::SMP_W-1], min_q};
	assign span     = {max_q[mmc_pkg::SMP_W-1], max_q} - {min_q[mmc_pkg::SMP_W-1], min_q};
	assign diff     = {smp[mmc_pkg::SMP_W-1], smp} - {off_q[mmc_pkg::SMP_W-1], off_q};

	assign num = mmc_pkg::NUM_W'({ctl.sum, 15'b0}) +
	             mmc_pkg::NUM_W'(d_q) * mmc_pkg::NUM_W'(mmc_pkg::AXES);
	assign den = mmc_pkg::DEN_W'(d_q) * mmc_pkg::DEN_W'(2 * mmc_pkg::AXES);
	assign div_start = (ctl.op == mmc_pkg::OP_DIV) && (d_q != '0);

	mmc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num),
		.den    (den),
		.busy   (div_busy),
		.done   (div_done),
		.quo    (div_quo)
	);

	always_ff @(posedge clk) begin
		case (ctl.op)
			mmc_pkg::OP_CLEAR: begin
				min_q <= mmc_pkg::SMP_MAX;
				max_q <= mmc_pkg::SMP_MIN;
			end
			mmc_pkg::OP_TRACK: begin
				if (smp < min_q) min_q <= smp;
				if (smp > max_q) max_q <= smp;
			end
			mmc_pkg::OP_PRESET: begin
				off_q   <= preset_off;
				scale_q <= preset_scl;
			end
			mmc_pkg::OP_OFFS: begin
				off_q <= pair_sum[mmc_pkg::SMP_W:1];
				d_q   <= (max_q >= min_q) ? span[mmc_pkg::D_W-1:0] : '0;
			end
			mmc_pkg::OP_DIV: begin
				if (d_q == '0) scale_q <= mmc_pkg::SCALE_SAT;
			end
			default: begin
			end
		endcase
		if (div_done) scale_q <= div_quo;
	end

	// correction pipeline runs every cycle; the sequencer picks the result when ready
	assign rnd     = mul2_s2 + mmc_pkg::MUL2_W'(64'sd1 << (mmc_pkg::RND_SH - 1));
	assign shifted = rnd[mmc_pkg::MUL2_W-1:mmc_pkg::RND_SH];

	always_ff @(posedge clk) begin
		mul1_s1 <= diff * $signed({1'b0, scale_q});
		mul2_s2 <= mul1_s1 * $signed({1'b0, inv});
		if (shifted > $signed({{(mmc_pkg::MUL2_W-mmc_pkg::RND_SH-mmc_pkg::SMP_W){1'b0}},
		                        mmc_pkg::SMP_MAX}))
			res_q <= mmc_pkg::SMP_MAX;
		else if (shifted < $signed({{(mmc_pkg::MUL2_W-mmc_pkg::RND_SH-mmc_pkg::SMP_W){1'b1}},
		                             mmc_pkg::SMP_MIN}))
			res_q <= mmc_pkg::SMP_MIN;
		else
			res_q <= shifted[mmc_pkg::SMP_W-1:0];
	end

	assign sts.busy = div_busy;
	assign sts.d    = d_q;
	assign res      = res_q;

endmodule

// ===== hw/rtl/mag_minmax_hard_soft_iron_cal_top.sv =====
// Top level of the magnetometer min/max calibration block: registers, sequencer, lanes.
// Depends on mmc_pkg and mmc_lane.
//
// Usage: each input word carries kind (0 sample, 1 start) and a 3-axis sample.
// Every word produces exactly one output word with valid_res, cal_x/y/z and the
// mode after the word. Input and output use valid/stall; a word moves at an edge
// with valid high and stall low. One word is in flight at a time: in_stall stays
// high from acceptance until the result has been taken off the output register.
// Start, preset and collect words complete in the execute state; a done-mode sample
// waits on the two-stage multiply in each lane, and the compute word waits on the
// 17-step divider in each lane that runs the three axes in parallel. Back to back,
// the next word is taken once the previous result has left the output register.
// A stalled result holds in the output register and no new word is taken. Reset
// returns to idle mode with the preset configuration values; the first sample after
// reset, if no start word comes first, loads the presets.
// Configuration goes through the APB port at byte address 4*index.
module mag_minmax_hard_soft_iron_cal_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [mmc_pkg::ADDR_W-1:0]        paddr,
	input  logic [31:0]                       pwdata,
	output logic [31:0]                       prdata,
	output logic                              pready,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              kind,
	input  logic signed [mmc_pkg::SMP_W-1:0]  mag_x,
	input  logic signed [mmc_pkg::SMP_W-1:0]  mag_y,
	input  logic signed [mmc_pkg::SMP_W-1:0]  mag_z,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              valid_res,
	output logic signed [mmc_pkg::SMP_W-1:0]  cal_x,
	output logic signed [mmc_pkg::SMP_W-1:0]  cal_y,
	output logic signed [mmc_pkg::SMP_W-1:0]  cal_z,
	output logic [1:0]                        cal_mode
);

	typedef enum logic [2:0] {
		ST_READY,
		ST_EXEC,
		ST_SUM,
		ST_DIV,
		ST_DIVW,
		ST_AP
	} state_t;

	state_t                           state_q;
	mmc_pkg::mode_t                   mode_q;
	logic [mmc_pkg::CNT_W-1:0]        collected_q;
	logic [1:0]                       ap_cnt_q;
	logic                             kind_q;
	logic signed [mmc_pkg::SMP_W-1:0] smp_q [0:2];
	logic [mmc_pkg::SUM_W-1:0]        sum_q;
	logic                             out_valid_q;
	logic                             valid_res_q;
	logic signed [mmc_pkg::SMP_W-1:0] cal_q [0:2];
	logic [1:0]                       cal_mode_q;

	logic [15:0]                      target_q;
	logic [15:0]                      inv_q;
	logic signed [mmc_pkg::SMP_W-1:0] poff_q [0:2];
	logic [mmc_pkg::SCL_W-1:0]        pscl_q [0:2];

	mmc_pkg::lane_ctl_t               ctl;
	mmc_pkg::lane_sts_t               sts [0:2];
	logic signed [mmc_pkg::SMP_W-1:0] res_w [0:2];
	logic [mmc_pkg::SUM_W-1:0]        sum_n;
	logic                             busy_any;
	logic [mmc_pkg::CNT_W-1:0]        coll_n;
	logic                             cfg_wr;
	logic                             in_acc;
	mmc_pkg::reg_idx_t                idx;

	// configuration registers
	assign cfg_wr = psel && penable && pwrite;
	assign idx    = mmc_pkg::reg_idx_t'(paddr[mmc_pkg::ADDR_W-1:2]);
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q  <= 16'd500;
			inv_q     <= 16'd65535;
			poff_q[0] <= -24'sd144891;
			poff_q[1] <= 24'sd95081;
			poff_q[2] <= 24'sd68237;
			pscl_q[0] <= 16'd16251;
			pscl_q[1] <= 16'd16141;
			pscl_q[2] <= 16'd16774;
		end else if (cfg_wr) begin
			case (idx)
				mmc_pkg::REG_TARGET: target_q  <= pwdata[15:0];
				mmc_pkg::REG_INV:    inv_q     <= pwdata[15:0];
				mmc_pkg::REG_OFF_X:  poff_q[0] <= pwdata[mmc_pkg::SMP_W-1:0];
				mmc_pkg::REG_OFF_Y:  poff_q[1] <= pwdata[mmc_pkg::SMP_W-1:0];
				mmc_pkg::REG_OFF_Z:  poff_q[2] <= pwdata[mmc_pkg::SMP_W-1:0];
				mmc_pkg::REG_SCL_X:  pscl_q[0] <= pwdata[mmc_pkg::SCL_W-1:0];
				mmc_pkg::REG_SCL_Y:  pscl_q[1] <= pwdata[mmc_pkg::SCL_W-1:0];
				mmc_pkg::REG_SCL_Z:  pscl_q[2] <= pwdata[mmc_pkg::SCL_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (idx)
			mmc_pkg::REG_TARGET: prdata = {16'b0, target_q};
			mmc_pkg::REG_INV:    prdata = {16'b0, inv_q};
			mmc_pkg::REG_OFF_X:  prdata = 32'(poff_q[0]);
			mmc_pkg::REG_OFF_Y:  prdata = 32'(poff_q[1]);
			mmc_pkg::REG_OFF_Z:  prdata = 32'(poff_q[2]);
			mmc_pkg::REG_SCL_X:  prdata = {16'b0, pscl_q[0]};
			mmc_pkg::REG_SCL_Y:  prdata = {16'b0, pscl_q[1]};
			mmc_pkg::REG_SCL_Z:  prdata = {16'b0, pscl_q[2]};
			default:             prdata = '0;
		endcase
	end

	// lanes
	for (genvar i = 0; i < 3; i++) begin : g_axis
		if (i < mmc_pkg::AXES) begin : g_lane
			mmc_lane u_lane (
				.clk        (clk),
				.arst_n     (arst_n),
				.ctl        (ctl),
				.smp        (smp_q[i]),
				.preset_off (poff_q[i]),
				.preset_scl (pscl_q[i]),
				.inv        (inv_q),
				.sts        (sts[i]),
				.res        (res_w[i])
			);
		end else begin : g_none
			assign sts[i]   = '0;
			assign res_w[i] = '0;
		end
	end

	// merge: sum of spans and divider activity across lanes
	always_comb begin
		sum_n    = '0;
		busy_any = 1'b0;
		for (int i = 0; i < 3; i++) begin
			sum_n    = sum_n + mmc_pkg::SUM_W'(sts[i].d);
			busy_any = busy_any | sts[i].busy;
		end
	end

	always_comb begin
		ctl.op  = mmc_pkg::OP_NONE;
		ctl.sum = sum_q;
		case (state_q)
			ST_EXEC: begin
				if (kind_q) begin
					ctl.op = mmc_pkg::OP_CLEAR;
				end else begin
					case (mode_q)
						mmc_pkg::MODE_IDLE:    ctl.op = mmc_pkg::OP_PRESET;
						mmc_pkg::MODE_COLLECT: ctl.op = mmc_pkg::OP_TRACK;
						mmc_pkg::MODE_COMPUTE: ctl.op = mmc_pkg::OP_OFFS;
						default:               ctl.op = mmc_pkg::OP_NONE;
					endcase
				end
			end
			ST_DIV:  ctl.op = mmc_pkg::OP_DIV;
			default: ctl.op = mmc_pkg::OP_NONE;
		endcase
	end

	assign coll_n   = (collected_q == '1) ? collected_q : collected_q + 1'b1;
	assign in_stall = (state_q != ST_READY) || out_valid_q;
	assign in_acc   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_READY;
			mode_q      <= mmc_pkg::MODE_IDLE;
			collected_q <= '0;
			ap_cnt_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			case (state_q)
				ST_READY: begin
					if (in_acc) begin
						kind_q   <= kind;
						smp_q[0] <= mag_x;
						smp_q[1] <= mag_y;
						smp_q[2] <= mag_z;
						state_q  <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					valid_res_q <= 1'b0;
					cal_q[0]    <= '0;
					cal_q[1]    <= '0;
					cal_q[2]    <= '0;
					if (kind_q) begin
						collected_q <= '0;
						mode_q      <= mmc_pkg::MODE_COLLECT;
						cal_mode_q  <= mmc_pkg::MODE_COLLECT;
						out_valid_q <= 1'b1;
						state_q     <= ST_READY;
					end else begin
						case (mode_q)
							mmc_pkg::MODE_IDLE: begin
								mode_q      <= mmc_pkg::MODE_DONE;
								cal_mode_q  <= mmc_pkg::MODE_DONE;
								out_valid_q <= 1'b1;
								state_q     <= ST_READY;
							end
							mmc_pkg::MODE_COLLECT: begin
								collected_q <= coll_n;
								if (coll_n >= target_q) begin
									mode_q     <= mmc_pkg::MODE_COMPUTE;
									cal_mode_q <= mmc_pkg::MODE_COMPUTE;
								end else begin
									cal_mode_q <= mmc_pkg::MODE_COLLECT;
								end
								out_valid_q <= 1'b1;
								state_q     <= ST_READY;
							end
							mmc_pkg::MODE_COMPUTE: begin
								state_q <= ST_SUM;
							end
							default: begin
								ap_cnt_q <= '0;
								state_q  <= ST_AP;
							end
						endcase
					end
				end
				ST_SUM: begin
					sum_q   <= sum_n;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					state_q <= ST_DIVW;
				end
				ST_DIVW: begin
					if (!busy_any) begin
						mode_q      <= mmc_pkg::MODE_DONE;
						cal_mode_q  <= mmc_pkg::MODE_DONE;
						out_valid_q <= 1'b1;
						state_q     <= ST_READY;
					end
				end
				ST_AP: begin
					ap_cnt_q <= ap_cnt_q + 1'b1;
					// lane result is ready after the two multiply stages and the round
					if (ap_cnt_q == 2'd2) begin
						valid_res_q <= 1'b1;
						cal_q[0]    <= res_w[0];
						cal_q[1]    <= res_w[1];
						cal_q[2]    <= res_w[2];
						cal_mode_q  <= mmc_pkg::MODE_DONE;
						out_valid_q <= 1'b1;
						state_q     <= ST_READY;
					end
				end
				default: begin
					state_q <= ST_READY;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign valid_res = valid_res_q;
	assign cal_x     = cal_q[0];
	assign cal_y     = cal_q[1];
	assign cal_z     = cal_q[2];
	assign cal_mode  = cal_mode_q;

`ifndef SYNTH
	a_valid_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && valid_res |-> cal_mode == mmc_pkg::MODE_DONE)
		else $error("calibrated word outside done mode");

	a_zero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !valid_res |-> cal_x == '0 && cal_y == '0 && cal_z == '0)
		else $error("uncalibrated word carries nonzero fields");

	a_divw_mode: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIVW |-> mode_q == mmc_pkg::MODE_COMPUTE)
		else $error("divider wait outside compute mode");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EXEC |=> !(in_valid && !in_stall))
		else $error("word accepted while previous word in flight");
`endif

endmodule

// ===== dv/mag_minmax_hard_soft_iron_cal_top_tb.sv =====
// Self-checking testbench for the magnetometer min/max hard/soft-iron calibration top.
// Depends on mmc_pkg and mag_minmax_hard_soft_iron_cal_top; predicts every output word
// in-line and drives configuration over the APB port between phases.
`timescale 1ns / 100ps

module mag_minmax_hard_soft_iron_cal_top_tb;
	import mmc_pkg::*;

	typedef struct {
		logic                     start;
		logic signed [SMP_W-1:0]  x, y, z;
	} mag_word_t;

	typedef struct {
		logic                     vld;
		logic signed [SMP_W-1:0]  x, y, z;
		logic [1:0]               mode;
	} cal_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic in_valid = 1'b0, in_stall;
	logic kind = 1'b0;
	logic signed [SMP_W-1:0] mag_x = '0, mag_y = '0, mag_z = '0;
	logic out_valid, out_stall = 1'b0;
	logic valid_res;
	logic signed [SMP_W-1:0] cal_x, cal_y, cal_z;
	logic [1:0] cal_mode;

	mag_minmax_hard_soft_iron_cal_top dut (.*);

	always #5 clk = ~clk;

	// register shadows
	logic [15:0]             tgt_q, inv_q;
	logic signed [SMP_W-1:0] pre_off [3];
	logic [15:0]             pre_scl [3];
	// calibration state
	mode_t                   st_mode;
	logic signed [SMP_W-1:0] trk_min [3], trk_max [3], hard_off [3];
	logic [15:0]             soft_scl [3];
	logic [15:0]             n_coll;

	mag_word_t pend_q[$];
	cal_word_t cal_exp_q[$];
	mag_word_t cur;
	int n_pushed = 0, n_taken = 0, n_err = 0;
	int gap_left = 0, stall_left = 0;
	bit gaps_on = 1'b1;
	longint cycles = 0;

	function automatic logic signed [SMP_W-1:0] corr_axis(logic signed [SMP_W-1:0] s,
			logic signed [SMP_W-1:0] off, logic [15:0] sc);
		longint p, q;
		p = (longint'(s) - longint'(off)) * longint'(sc) * longint'(inv_q);
		q = (p + (64'sd1 <<< 25)) >>> RND_SH;
		if (q > 8388607) q = 8388607;
		if (q < -8388608) q = -8388608;
		return q[SMP_W-1:0];
	endfunction

	task automatic solve_cal();
		longint d [3];
		longint sum, den, q, s;
		sum = 0;
		for (int i = 0; i < 3; i++) begin
			s = longint'(trk_max[i]) + longint'(trk_min[i]);
			hard_off[i] = s >>> 1;
			d[i] = (trk_max[i] >= trk_min[i]) ? longint'(trk_max[i]) - longint'(trk_min[i]) : 0;
			sum += d[i];
		end
		for (int i = 0; i < 3; i++) begin
			if (d[i] == 0) soft_scl[i] = 16'hFFFF;
			else begin
				den = 3 * d[i];
				q = ((sum <<< 15) + den) / (den * 2);
				soft_scl[i] = (q > 65535) ? 16'hFFFF : q[15:0];
			end
		end
	endtask

	task automatic predict_cal(mag_word_t w);
		cal_word_t e;
		logic signed [SMP_W-1:0] smp [3];
		smp[0] = w.x; smp[1] = w.y; smp[2] = w.z;
		e.vld = 1'b0; e.x = '0; e.y = '0; e.z = '0;
		if (w.start) begin
			for (int i = 0; i < 3; i++) begin
				trk_min[i] = SMP_MAX;
				trk_max[i] = SMP_MIN;
			end
			n_coll = '0;
			st_mode = MODE_COLLECT;
		end else if (st_mode == MODE_IDLE) begin
			for (int i = 0; i < 3; i++) begin
				hard_off[i] = pre_off[i];
				soft_scl[i] = pre_scl[i];
			end
			st_mode = MODE_DONE;
		end else if (st_mode == MODE_COLLECT) begin
			for (int i = 0; i < 3; i++) begin
				if (smp[i] < trk_min[i]) trk_min[i] = smp[i];
				if (smp[i] > trk_max[i]) trk_max[i] = smp[i];
			end
			if (n_coll != 16'hFFFF) n_coll++;
			if (n_coll >= tgt_q) st_mode = MODE_COMPUTE;
		end else if (st_mode == MODE_COMPUTE) begin
			solve_cal();
			st_mode = MODE_DONE;
		end else begin
			e.x = corr_axis(w.x, hard_off[0], soft_scl[0]);
			e.y = corr_axis(w.y, hard_off[1], soft_scl[1]);
			e.z = corr_axis(w.z, hard_off[2], soft_scl[2]);
			e.vld = 1'b1;
		end
		e.mode = st_mode;
		cal_exp_q.push_back(e);
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			gap_left <= 0;
		end else begin
			if (in_valid && !in_stall) begin
				predict_cal(cur);
				n_taken++;
			end
			if (!in_valid || !in_stall) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					in_valid <= 1'b0;
				end else if (pend_q.size() > 0) begin
					cur = pend_q.pop_front();
					kind <= cur.start;
					mag_x <= cur.x;
					mag_y <= cur.y;
					mag_z <= cur.z;
					in_valid <= 1'b1;
					if (gaps_on && $urandom_range(0, 5) == 0) gap_left <= $urandom_range(1, 15);
				end else
					in_valid <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left <= 0;
		end else begin
			cycles++;
			if (out_valid && !out_stall) begin
				if (cal_exp_q.size() == 0) begin
					n_err++;
					if (n_err <= 10) $display("unexpected output word: mode %0d", cal_mode);
				end else begin
					cal_word_t e;
					e = cal_exp_q.pop_front();
					if (e.vld !== valid_res || e.x !== cal_x || e.y !== cal_y || e.z !== cal_z
							|| e.mode !== cal_mode) begin
						n_err++;
						if (n_err <= 10)
							$display("mismatch: exp v%0d %0d %0d %0d m%0d, got v%0d %0d %0d %0d m%0d",
								e.vld, e.x, e.y, e.z, e.mode,
								valid_res, cal_x, cal_y, cal_z, cal_mode);
					end
				end
			end
			if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
				if (gaps_on && $urandom_range(0, 5) == 0) stall_left <= $urandom_range(1, 15);
			end
			if (cycles > 600000) begin
				$display("mag_minmax_hard_soft_iron_cal_top regression: fail");
				$finish;
			end
		end
	end

	function automatic logic signed [SMP_W-1:0] rnd_field();
		case ($urandom_range(0, 9))
			0: return SMP_MAX;
			1: return SMP_MIN;
			2: return '0;
			3: return $urandom_range(0, 4000) - 2000;
			default: return $urandom();
		endcase
	endfunction

	task automatic add_word(logic st, logic signed [SMP_W-1:0] x, y, z);
		mag_word_t w;
		w.start = st; w.x = x; w.y = y; w.z = z;
		pend_q.push_back(w);
		n_pushed++;
	endtask

	task automatic add_rnd(logic st);
		add_word(st, rnd_field(), rnd_field(), rnd_field());
	endtask

	task automatic apb_write(reg_idx_t idx, logic [31:0] val);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= ADDR_W'(idx) << 2; pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		case (idx)
			REG_TARGET: tgt_q = val[15:0];
			REG_INV:    inv_q = val[15:0];
			REG_OFF_X:  pre_off[0] = val[23:0];
			REG_OFF_Y:  pre_off[1] = val[23:0];
			REG_OFF_Z:  pre_off[2] = val[23:0];
			REG_SCL_X:  pre_scl[0] = val[15:0];
			REG_SCL_Y:  pre_scl[1] = val[15:0];
			default:    pre_scl[2] = val[15:0];
		endcase
	endtask

	task automatic drain();
		while (n_taken != n_pushed || cal_exp_q.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	function automatic logic [15:0] rnd16();
		case ($urandom_range(0, 5))
			0: return 16'h0000;
			1: return 16'hFFFF;
			default: return $urandom();
		endcase
	endfunction

	initial begin
		int n, tgt, pass_no;
		logic signed [SMP_W-1:0] fx;
		tgt_q = 16'd500; inv_q = 16'hFFFF;
		pre_off[0] = -144891; pre_off[1] = 95081; pre_off[2] = 68237;
		pre_scl[0] = 16251; pre_scl[1] = 16141; pre_scl[2] = 16774;
		st_mode = MODE_IDLE;
		n_coll = '0;
		for (int i = 0; i < 3; i++) begin
			trk_min[i] = SMP_MAX; trk_max[i] = SMP_MIN;
			hard_off[i] = '0; soft_scl[i] = '0;
		end
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: presets load on first sample, then done-mode extremes, then starts
		add_word(1'b0, 24'sd1000, -24'sd1000, 24'sd0);
		add_word(1'b0, SMP_MAX, SMP_MAX, SMP_MAX);
		add_word(1'b0, SMP_MIN, SMP_MIN, SMP_MIN);
		add_word(1'b0, SMP_MAX, SMP_MIN, '0);
		add_word(1'b0, '0, '0, '0);
		add_word(1'b0, -24'sd144891, 24'sd95081, 24'sd68237);
		add_word(1'b1, '0, '0, '0);
		add_word(1'b0, SMP_MAX, SMP_MIN, 24'sd5);
		add_word(1'b0, SMP_MIN, SMP_MAX, 24'sd5);
		add_word(1'b1, SMP_MAX, SMP_MAX, SMP_MAX);
		add_word(1'b0, 24'sd3, 24'sd3, 24'sd3);
		drain();

		// target zero: first collected sample reaches it; all radii zero
		apb_write(REG_TARGET, 32'd0);
		add_word(1'b1, '0, '0, '0);
		add_word(1'b0, 24'sd7, -24'sd9, 24'sd11);
		add_word(1'b0, '0, '0, '0);
		add_word(1'b0, SMP_MAX, SMP_MIN, 24'sd7);
		add_word(1'b0, SMP_MIN, SMP_MAX, -24'sd7);
		drain();

		pass_no = 0;
		while (n_pushed < 650) begin
			case (pass_no)
				0: begin
					tgt = 65535;
					apb_write(REG_INV, 32'd0);
				end
				1: begin
					tgt = 2;
					apb_write(REG_INV, 32'hFFFF);
				end
				default: begin
					tgt = $urandom_range(0, 9) == 0 ? 0 : $urandom_range(1, 10);
					apb_write(REG_INV, rnd16());
				end
			endcase
			apb_write(REG_TARGET, tgt);
			apb_write(REG_OFF_X, {{8{1'b0}}, rnd_field()});
			apb_write(REG_OFF_Y, {{8{1'b1}}, rnd_field()});
			apb_write(REG_OFF_Z, $urandom());
			apb_write(REG_SCL_X, rnd16());
			apb_write(REG_SCL_Y, rnd16());
			apb_write(REG_SCL_Z, rnd16());
			if (n_pushed > 560) gaps_on = 1'b0;
			if (pass_no == 0) begin
				add_rnd(1'b1);
				for (int k = 0; k < 5; k++) add_rnd(1'b0);
			end else begin
				add_rnd(1'b1);
				fx = rnd_field();
				n = (tgt == 0) ? 1 : tgt;
				for (int k = 0; k < n; k++) begin
					// hold one axis still now and then for a zero radius
					if (pass_no % 5 == 3) add_word(1'b0, fx, rnd_field(), rnd_field());
					else if ($urandom_range(0, 29) == 0) add_rnd(1'b1);
					else add_rnd(1'b0);
				end
				add_rnd(1'b0);
				n = $urandom_range(4, 14);
				for (int k = 0; k < n; k++)
					add_rnd($urandom_range(0, 24) == 0);
			end
			drain();
			pass_no++;
		end

		if (n_err == 0)
			$display("mag_minmax_hard_soft_iron_cal_top regression: pass");
		else
			$display("mag_minmax_hard_soft_iron_cal_top regression: fail");
		$finish;
	end

endmodule

// ===== mag_minmax_hard_soft_iron_cal_top.f =====
hw/rtl/mmc_pkg.sv
hw/rtl/mmc_div.sv
hw/rtl/mmc_lane.sv
hw/rtl/mag_minmax_hard_soft_iron_cal_top.sv
dv/mag_minmax_hard_soft_iron_cal_top_tb.sv
